// File: hw/rtl/vsc_pkg.sv
// ----------------------------------------------------------------------------
// vsc_pkg
// shared types, codes and constants of the vending slot controller
// ----------------------------------------------------------------------------
package vsc_pkg;

    // slot store geometry
    localparam int SLOTS          = 6;
    localparam int STOCK_AT_RESET = 10;
    localparam int SLOT_W         = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [7:0] NO_SLOT = 8'hFF;

    // base prices in cents, slots past the list take the last one
    localparam int PRICE_LIST_LEN = 6;
    localparam logic [15:0] BASE_PRICE [PRICE_LIST_LEN] = '{
        16'd150, 16'd100, 16'd200, 16'd125, 16'd175, 16'd175
    };

    // configuration register indexes and reset values
    localparam logic [1:0] REG_IR_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_SUCCESS_HOLD = 2'd1;
    localparam logic [1:0] REG_ADMIN_PIN    = 2'd2;

    localparam logic [7:0]  IR_TIMEOUT_RESET   = 8'd60;
    localparam logic [7:0]  SUCCESS_HOLD_RESET = 8'd40;
    localparam logic [31:0] ADMIN_PIN_RESET    = 32'h0102_0304;

    // event opcodes
    localparam logic [3:0] OP_SELECT      = 4'd0;
    localparam logic [3:0] OP_DISPENSE    = 4'd1;
    localparam logic [3:0] OP_AUTH        = 4'd2;
    localparam logic [3:0] OP_RESTOCK     = 4'd3;
    localparam logic [3:0] OP_SET_PRICE   = 4'd4;
    localparam logic [3:0] OP_ADMIN_RESET = 4'd5;
    localparam logic [3:0] OP_LOCK        = 4'd6;
    localparam logic [3:0] OP_UNLOCK      = 4'd7;
    localparam logic [3:0] OP_IR_NOTE     = 4'd8;
    localparam logic [3:0] OP_RESET_ERROR = 4'd9;
    localparam logic [3:0] OP_TICK        = 4'd10;

    // machine modes
    localparam logic [2:0] MODE_IDLE       = 3'd0;
    localparam logic [2:0] MODE_SELECTED   = 3'd1;
    localparam logic [2:0] MODE_DISPENSING = 3'd2;
    localparam logic [2:0] MODE_DISPENSED  = 3'd3;
    localparam logic [2:0] MODE_ADMIN      = 3'd4;
    localparam logic [2:0] MODE_ERROR      = 3'd5;

    // fault codes
    localparam logic [2:0] FAULT_NONE    = 3'd0;
    localparam logic [2:0] FAULT_JAM     = 3'd1;
    localparam logic [2:0] FAULT_AUTH    = 3'd2;
    localparam logic [2:0] FAULT_INVALID = 3'd3;
    localparam logic [2:0] FAULT_EMPTY   = 3'd4;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [7:0]  slot_number;
        logic [7:0]  stock_value;
        logic [15:0] new_price;
        logic [31:0] pin_entered;
        logic        ir_seen;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  machine_state;
        logic [2:0]  error_code;
        logic [7:0]  chosen_slot;
        logic        locked_flag;
        logic        admin_flag;
        logic        servo_start;
        logic [7:0]  slot_stock;
        logic [31:0] dispensed_total;
    } t_out_item;

    // one slot store entry
    typedef struct packed {
        logic [15:0] price;
        logic [7:0]  stock;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_entry            data;
    } t_mem_wr;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'b01,
        CTL_EXEC = 2'b10
    } t_ctl;

    function automatic t_entry init_entry(input logic [SLOT_W-1:0] idx);
        t_entry e;
        e.stock = 8'(STOCK_AT_RESET);
        if (int'(idx) >= PRICE_LIST_LEN - 1) begin
            e.price = BASE_PRICE[PRICE_LIST_LEN-1];
        end else begin
            e.price = BASE_PRICE[3'(idx)];
        end
        return e;
    endfunction

endpackage

// File: hw/rtl/vsc_slot_mem.sv
// ----------------------------------------------------------------------------
// vsc_slot_mem
// slot store: price and stock per slot, two registered read ports, one write
// ----------------------------------------------------------------------------
module vsc_slot_mem
    import vsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_rd_a_addr,
    input  logic [SLOT_W-1:0] i_rd_b_addr,
    input  t_mem_wr           i_wr,
    output t_entry            o_rd_a,
    output t_entry            o_rd_b
);

    t_entry            r_mem [SLOTS];
    logic [SLOTS-1:0]  r_vld;

    t_entry            r_a_data;
    t_entry            r_b_data;
    logic              r_a_vld;
    logic              r_b_vld;
    logic [SLOT_W-1:0] r_a_addr;
    logic [SLOT_W-1:0] r_b_addr;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_a_data <= r_mem[i_rd_a_addr];
            r_b_data <= r_mem[i_rd_b_addr];
            r_a_vld  <= r_vld[i_rd_a_addr];
            r_b_vld  <= r_vld[i_rd_b_addr];
            r_a_addr <= i_rd_a_addr;
            r_b_addr <= i_rd_b_addr;
        end
    end

    // written-since-reset bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // entries never written read as their reset contents
    assign o_rd_a = r_a_vld ? r_a_data : init_entry(r_a_addr);
    assign o_rd_b = r_b_vld ? r_b_data : init_entry(r_b_addr);

endmodule

// File: hw/rtl/vending_slot_controller.sv
// ----------------------------------------------------------------------------
// vending_slot_controller
// vending machine event controller with per-slot stock and price store
// ----------------------------------------------------------------------------
// usage
//   input channel: one event per transaction (i_in_valid / o_in_stall),
//   payload t_in_item. every event yields exactly one status transaction on
//   the output channel (o_out_valid / i_out_stall), payload t_out_item.
//   configuration: apb-style port, timeout at 0x0, success hold at 0x4,
//   admin pin at 0x8. pready is tied high; write only while idle.
// sequencing
//   an event is accepted in the idle state and the slot store is read at that
//   edge; the execute state then modifies, writes back and loads the output register.
//   a new event is taken only once the previous one has left the execute state;
//   this is set by the single read-modify-write pass on the slot store.
// stall
//   a finished status may sit in the output register while the next event is
//   accepted; that event holds in its execute cycle until the register frees.
// reset
//   synchronous active-low. control, mode and config registers return to
//   their defaults; the slot store comes back through per-entry valid bits,
//   so no clearing pass is needed and events are taken right after reset.
// ----------------------------------------------------------------------------
module vending_slot_controller
    import vsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // status channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // control
    t_ctl        r_ctl;
    t_in_item    r_item;
    logic        in_accept;
    logic        exec_go;

    // machine state
    logic [2:0]  r_mode,   n_mode;
    logic [2:0]  r_fault,  n_fault;
    logic [7:0]  r_picked, n_picked;
    logic        r_lock,   n_lock;
    logic        r_admin,  n_admin;
    logic [31:0] r_count,  n_count;
    logic [7:0]  r_timer,  n_timer;

    // configuration
    logic [7:0]  r_ir_timeout;
    logic [7:0]  r_hold;
    logic [31:0] r_pin;
    logic        cfg_wr;

    // output register
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;

    // slot store access
    logic [SLOT_W-1:0] rd_a_addr;
    logic [SLOT_W-1:0] rd_b_addr;
    t_entry            rd_a;
    t_entry            rd_b;
    t_mem_wr           wr;

    logic              slot_ok;
    logic              picked_ok;
    logic [SLOT_W-1:0] item_addr;
    logic [SLOT_W-1:0] picked_addr;
    logic [7:0]        timer_inc;
    logic              busy;
    logic              accepted;
    logic              servo;
    logic [7:0]        sstock;

    // ------------------------------------------------------------------------
    // handshake and sequencing
    // ------------------------------------------------------------------------
    assign o_in_stall = (r_ctl != CTL_IDLE);
    assign in_accept  = i_in_valid && (r_ctl == CTL_IDLE);
    // execute only when the output register is free or being drained
    assign exec_go    = (r_ctl == CTL_EXEC) && !(r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= CTL_IDLE;
        end else begin
            unique case (r_ctl)
                CTL_IDLE: begin
                    if (in_accept) r_ctl <= CTL_EXEC;
                end
                CTL_EXEC: begin
                    if (exec_go) r_ctl <= CTL_IDLE;
                end
                default: r_ctl <= CTL_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) r_item <= i_in_item;
    end

    // ------------------------------------------------------------------------
    // slot store: port a follows the event's slot, port b the picked slot
    // ------------------------------------------------------------------------
    assign rd_a_addr = (i_in_item.slot_number < 8'(SLOTS))
                     ? i_in_item.slot_number[SLOT_W-1:0] : '0;
    assign rd_b_addr = picked_ok ? picked_addr : '0;

    vsc_slot_mem u_slot_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_accept),
        .i_rd_a_addr (rd_a_addr),
        .i_rd_b_addr (rd_b_addr),
        .i_wr        (wr),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    // ------------------------------------------------------------------------
    // event execution
    // ------------------------------------------------------------------------
    assign slot_ok     = r_item.slot_number < 8'(SLOTS);
    assign picked_ok   = r_picked < 8'(SLOTS);
    assign item_addr   = r_item.slot_number[SLOT_W-1:0];
    assign picked_addr = r_picked[SLOT_W-1:0];
    assign timer_inc   = r_timer + 8'd1;
    assign busy        = (r_mode == MODE_DISPENSING) || (r_mode == MODE_DISPENSED);

    always_comb begin
        n_mode   = r_mode;
        n_fault  = r_fault;
        n_picked = r_picked;
        n_lock   = r_lock;
        n_admin  = r_admin;
        n_count  = r_count;
        n_timer  = r_timer;
        accepted = 1'b1;
        servo    = 1'b0;
        wr.en    = 1'b0;
        wr.addr  = picked_addr;
        wr.data  = rd_b;

        priority if (r_item.opcode == OP_TICK) begin
            if (r_mode == MODE_DISPENSING) begin
                if (r_item.ir_seen) begin
                    // item confirmed: take it off the slot
                    if (picked_ok && (rd_b.stock != 8'd0)) begin
                        wr.en         = 1'b1;
                        wr.addr       = picked_addr;
                        wr.data.price = rd_b.price;
                        wr.data.stock = rd_b.stock - 8'd1;
                    end
                    n_count  = r_count + 32'd1;
                    n_picked = NO_SLOT;
                    n_mode   = MODE_DISPENSED;
                    n_timer  = 8'd0;
                end else begin
                    n_timer = timer_inc;
                    if ((timer_inc >= r_ir_timeout) || (r_ir_timeout == 8'd0)) begin
                        n_mode  = MODE_ERROR;
                        n_fault = FAULT_JAM;
                    end
                end
            end else if (r_mode == MODE_DISPENSED) begin
                n_timer = timer_inc;
                if ((timer_inc >= r_hold) || (r_hold == 8'd0)) begin
                    n_mode = MODE_IDLE;
                end
            end
        end else if (busy) begin
            accepted = 1'b0;
        end else if (r_item.opcode == OP_SELECT) begin
            if (!r_lock && (r_mode != MODE_ERROR)) begin
                if (!slot_ok) begin
                    n_mode  = MODE_ERROR;
                    n_fault = FAULT_INVALID;
                end else if (rd_a.stock == 8'd0) begin
                    n_mode  = MODE_ERROR;
                    n_fault = FAULT_EMPTY;
                end else begin
                    n_picked = r_item.slot_number;
                    n_mode   = MODE_SELECTED;
                end
            end
        end else if (r_item.opcode == OP_DISPENSE) begin
            if (!r_lock && (r_mode == MODE_SELECTED)) begin
                n_mode  = MODE_DISPENSING;
                n_timer = 8'd0;
                servo   = 1'b1;
            end
        end else if (r_item.opcode == OP_AUTH) begin
            n_admin = (r_item.pin_entered == r_pin);
            if (r_item.pin_entered == r_pin) begin
                n_mode = MODE_ADMIN;
            end else begin
                n_mode  = MODE_ERROR;
                n_fault = FAULT_AUTH;
            end
        end else if ((r_item.opcode >= OP_RESTOCK) && (r_item.opcode <= OP_UNLOCK)) begin
            if (!r_admin) begin
                n_mode  = MODE_ERROR;
                n_fault = FAULT_AUTH;
            end else begin
                priority case (r_item.opcode)
                    OP_RESTOCK: begin
                        if (slot_ok) begin
                            wr.en         = 1'b1;
                            wr.addr       = item_addr;
                            wr.data.price = rd_a.price;
                            wr.data.stock = r_item.stock_value;
                        end
                    end
                    OP_SET_PRICE: begin
                        if (slot_ok) begin
                            wr.en         = 1'b1;
                            wr.addr       = item_addr;
                            wr.data.price = r_item.new_price;
                            wr.data.stock = rd_a.stock;
                        end
                    end
                    OP_ADMIN_RESET: begin
                        n_fault = FAULT_NONE;
                        n_mode  = MODE_IDLE;
                    end
                    OP_LOCK:   n_lock = 1'b1;
                    default:   n_lock = 1'b0;
                endcase
            end
        end else if (r_item.opcode == OP_RESET_ERROR) begin
            if (r_mode == MODE_ERROR) begin
                n_fault = FAULT_NONE;
                n_mode  = MODE_IDLE;
            end
        end else begin
            // ir note and unused opcodes leave everything as is
            n_mode = r_mode;
        end
    end

    // stock of the slot picked after the event, with the write forwarded
    always_comb begin
        if (n_picked < 8'(SLOTS)) begin
            if (wr.en && (wr.addr == n_picked[SLOT_W-1:0])) begin
                sstock = wr.data.stock;
            end else if (n_picked == r_picked) begin
                sstock = rd_b.stock;
            end else begin
                sstock = rd_a.stock;
            end
        end else begin
            sstock = 8'd0;
        end
    end

    always_comb begin
        n_out_item.accepted        = accepted;
        n_out_item.machine_state   = n_mode;
        n_out_item.error_code      = n_fault;
        n_out_item.chosen_slot     = n_picked;
        n_out_item.locked_flag     = n_lock;
        n_out_item.admin_flag      = n_admin;
        n_out_item.servo_start     = servo;
        n_out_item.slot_stock      = sstock;
        n_out_item.dispensed_total = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_fault  <= FAULT_NONE;
            r_picked <= NO_SLOT;
            r_lock   <= 1'b0;
            r_admin  <= 1'b0;
            r_count  <= '0;
            r_timer  <= '0;
        end else if (exec_go) begin
            r_mode   <= n_mode;
            r_fault  <= n_fault;
            r_picked <= n_picked;
            r_lock   <= n_lock;
            r_admin  <= n_admin;
            r_count  <= n_count;
            r_timer  <= n_timer;
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir_timeout <= IR_TIMEOUT_RESET;
            r_hold       <= SUCCESS_HOLD_RESET;
            r_pin        <= ADMIN_PIN_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_IR_TIMEOUT:   r_ir_timeout <= pwdata[7:0];
                REG_SUCCESS_HOLD: r_hold       <= pwdata[7:0];
                REG_ADMIN_PIN:    r_pin        <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IR_TIMEOUT:   prdata = {24'd0, r_ir_timeout};
            REG_SUCCESS_HOLD: prdata = {24'd0, r_hold};
            REG_ADMIN_PIN:    prdata = r_pin;
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// File: hw/rtl/vsc_checker.sv
// ----------------------------------------------------------------------------
// vsc_checker
// port-level checks on the status channel of the vending slot controller
// ----------------------------------------------------------------------------
module vsc_checker
    import vsc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled status transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("status transaction changed while stalled");

    // servo start only comes with an accepted event that enters dispensing
    a_servo_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.servo_start |->
            o_out_item.accepted && (o_out_item.machine_state == MODE_DISPENSING))
        else $error("servo start outside dispensing");

    // a busy refusal leaves the machine in a busy mode
    a_busy_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.accepted |->
            (o_out_item.machine_state == MODE_DISPENSING) ||
            (o_out_item.machine_state == MODE_DISPENSED))
        else $error("refused event outside a busy mode");

    // error mode always carries a fault code
    a_error_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.machine_state == MODE_ERROR) |->
            (o_out_item.error_code != FAULT_NONE))
        else $error("error mode without fault code");

    // no picked slot reads as zero stock
    a_no_slot_stock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.chosen_slot == NO_SLOT) |->
            (o_out_item.slot_stock == 8'd0))
        else $error("stock reported without a picked slot");

endmodule

bind vending_slot_controller vsc_checker u_vsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
